// ===== hdl/glmrs_pkg.sv =====
package glmrs_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 128;
    localparam int VALUE_BITS  = 4;
    localparam int CFG_BITS    = 8;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int SUM_BITS    = 18;
    localparam int COUNT_BITS  = 15;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_BITS-1:0] SIZE_RESET = CFG_BITS'(100);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COLUMN_COUNT = 1'b0,
        CFG_ROW_COUNT    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] height;
        logic [COL_BITS-1:0]   col;
        logic                  first_row;
        logic                  last_col;
        logic                  last_row;
    } pixel_ctx_t;

endpackage

// ===== hdl/glmrs_ram.sv =====
module glmrs_ram #(
    parameter int WIDTH     = 4,
    parameter int DEPTH     = 128,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/glmrs_scan.sv =====
module glmrs_scan
    import glmrs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    pixel_valid,
    input  logic                    pixel_stall,
    input  logic [VALUE_BITS-1:0]   pixel_height,
    input  logic                    hold,
    output logic                    rd_en,
    output logic [COL_BITS-1:0]     rd_addr,
    output logic                    ctx_valid,
    output pixel_ctx_t              ctx
);

    logic [CFG_BITS-1:0] col_count_reg;
    logic [CFG_BITS-1:0] row_count_reg;
    logic [COL_BITS-1:0] col_pos_reg, col_pos_next;
    logic [ROW_BITS-1:0] row_pos_reg, row_pos_next;
    logic                ctx_valid_reg, ctx_valid_next;
    pixel_ctx_t          ctx_reg, ctx_next;

    logic                accept;
    logic [CFG_BITS-1:0] cols_eff, rows_eff;
    logic [COL_BITS-1:0] col_last, col_eff;
    logic [ROW_BITS-1:0] row_last, row_eff;
    logic                is_last_col, is_last_row;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= SIZE_RESET;
            row_count_reg <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_COLUMN_COUNT: col_count_reg <= cfg_data;
                CFG_ROW_COUNT:    row_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign accept = pixel_valid && !pixel_stall;

    always_comb
    begin
        if (col_count_reg == '0)
            cols_eff = CFG_BITS'(1);
        else if (col_count_reg > CFG_BITS'(MAX_COLUMNS))
            cols_eff = CFG_BITS'(MAX_COLUMNS);
        else
            cols_eff = col_count_reg;

        if (row_count_reg == '0)
            rows_eff = CFG_BITS'(1);
        else if (row_count_reg > CFG_BITS'(MAX_ROWS))
            rows_eff = CFG_BITS'(MAX_ROWS);
        else
            rows_eff = row_count_reg;

        col_last = COL_BITS'(cols_eff - CFG_BITS'(1));
        row_last = ROW_BITS'(rows_eff - CFG_BITS'(1));
        col_eff  = (col_pos_reg > col_last) ? col_last : col_pos_reg;
        row_eff  = (row_pos_reg > row_last) ? row_last : row_pos_reg;
        is_last_col = (col_eff == col_last);
        is_last_row = (row_eff == row_last);

        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept)
        begin
            if (!is_last_col)
            begin
                col_pos_next = col_eff + COL_BITS'(1);
                row_pos_next = row_eff;
            end
            else
            begin
                col_pos_next = '0;
                row_pos_next = is_last_row ? '0 : row_eff + ROW_BITS'(1);
            end
        end

        ctx_next = ctx_reg;
        if (accept)
        begin
            ctx_next.height    = pixel_height;
            ctx_next.col       = col_eff;
            ctx_next.first_row = (row_eff == '0);
            ctx_next.last_col  = is_last_col;
            ctx_next.last_row  = is_last_row;
        end

        // a held pixel stays in the decide stage
        ctx_valid_next = accept || hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            ctx_valid_reg <= 1'b0;
        end
        else
        begin
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            ctx_valid_reg <= ctx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_next;
    end

    assign rd_en     = accept;
    assign rd_addr   = col_eff;
    assign ctx_valid = ctx_valid_reg;
    assign ctx       = ctx_reg;

endmodule

// ===== hdl/glmrs_eval.sv =====
module glmrs_eval
    import glmrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ctx_valid,
    input  pixel_ctx_t            ctx,
    input  logic [VALUE_BITS-1:0] up_rd_data,
    input  logic                  cand_rd_data,
    output logic                  val_wr_en,
    output logic [COL_BITS-1:0]   val_wr_addr,
    output logic [VALUE_BITS-1:0] val_wr_data,
    output logic                  cand_wr_en,
    output logic [COL_BITS-1:0]   cand_wr_addr,
    output logic                  cand_wr_data,
    output logic                  hold,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [SUM_BITS-1:0]   risk_sum,
    output logic [COUNT_BITS-1:0] minimum_count
);

    logic [VALUE_BITS-1:0] left_value_reg, left_value_next;
    logic                  left_partial_reg, left_partial_next;
    logic                  vfwd_valid_reg, vfwd_valid_next;
    logic [COL_BITS-1:0]   vfwd_addr_reg, vfwd_addr_next;
    logic [VALUE_BITS-1:0] vfwd_data_reg, vfwd_data_next;
    logic                  cfwd_valid_reg, cfwd_valid_next;
    logic [COL_BITS-1:0]   cfwd_addr_reg, cfwd_addr_next;
    logic                  cfwd_data_reg, cfwd_data_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [COL_BITS-1:0]   pend_addr_reg, pend_addr_next;
    logic                  pend_flag_reg, pend_flag_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0]   out_sum_reg, out_sum_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;

    logic                  emit, fire, first_col;
    logic [VALUE_BITS-1:0] up;
    logic                  cand_up;
    logic                  up_hit, left_full, left_hit, partial, own_hit;
    logic [VALUE_BITS:0]   up_term, left_term, own_term;
    logic [VALUE_BITS+1:0] sum_add;
    logic [1:0]            count_add;
    logic [SUM_BITS:0]     sum_total;
    logic [COUNT_BITS:0]   count_total;
    logic [SUM_BITS-1:0]   sum_sat;
    logic [COUNT_BITS-1:0] count_sat;

    always_comb
    begin
        emit      = ctx.last_col && ctx.last_row;
        hold      = ctx_valid && emit && out_valid_reg && result_stall;
        fire      = ctx_valid && !hold;
        first_col = (ctx.col == '0);

        // newest write wins over the registered memory read
        up      = (vfwd_valid_reg && vfwd_addr_reg == ctx.col) ? vfwd_data_reg : up_rd_data;
        cand_up = (cfwd_valid_reg && cfwd_addr_reg == ctx.col) ? cfwd_data_reg : cand_rd_data;

        up_hit    = !ctx.first_row && cand_up && (up < ctx.height);
        left_full = left_partial_reg && (left_value_reg < ctx.height);
        left_hit  = !first_col && ctx.last_row && left_full;
        partial   = (first_col || ctx.height < left_value_reg)
                    && (ctx.first_row || ctx.height < up);
        own_hit   = emit && partial;

        up_term   = up_hit   ? {1'b0, up} + (VALUE_BITS+1)'(1)             : '0;
        left_term = left_hit ? {1'b0, left_value_reg} + (VALUE_BITS+1)'(1) : '0;
        own_term  = own_hit  ? {1'b0, ctx.height} + (VALUE_BITS+1)'(1)     : '0;
        sum_add   = {1'b0, up_term} + {1'b0, left_term} + {1'b0, own_term};
        count_add = {1'b0, up_hit} + {1'b0, left_hit} + {1'b0, own_hit};

        sum_total   = {1'b0, sum_reg} + (SUM_BITS+1)'(sum_add);
        count_total = {1'b0, count_reg} + (COUNT_BITS+1)'(count_add);
        sum_sat     = sum_total[SUM_BITS] ? '1 : sum_total[SUM_BITS-1:0];
        count_sat   = count_total[COUNT_BITS] ? '1 : count_total[COUNT_BITS-1:0];

        // line buffer writes
        val_wr_en   = fire;
        val_wr_addr = ctx.col;
        val_wr_data = ctx.height;

        cand_wr_en   = 1'b0;
        cand_wr_addr = pend_addr_reg;
        cand_wr_data = pend_flag_reg;
        if (fire && !first_col && !ctx.last_row)
        begin
            cand_wr_en   = 1'b1;
            cand_wr_addr = ctx.col - COL_BITS'(1);
            cand_wr_data = left_full;
        end
        else if (fire && first_col && ctx.last_col && !ctx.last_row)
        begin
            cand_wr_en   = 1'b1;
            cand_wr_addr = ctx.col;
            cand_wr_data = partial;
        end
        else if (pend_valid_reg)
        begin
            cand_wr_en = 1'b1;
        end

        // the row-end flag goes out in the following cycle, when column zero writes none
        pend_valid_next = fire && !first_col && ctx.last_col && !ctx.last_row;
        pend_addr_next  = ctx.col;
        pend_flag_next  = partial;

        vfwd_valid_next = vfwd_valid_reg || val_wr_en;
        vfwd_addr_next  = val_wr_en ? val_wr_addr : vfwd_addr_reg;
        vfwd_data_next  = val_wr_en ? val_wr_data : vfwd_data_reg;
        cfwd_valid_next = cfwd_valid_reg || cand_wr_en;
        cfwd_addr_next  = cand_wr_en ? cand_wr_addr : cfwd_addr_reg;
        cfwd_data_next  = cand_wr_en ? cand_wr_data : cfwd_data_reg;

        left_value_next   = left_value_reg;
        left_partial_next = left_partial_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        out_sum_next      = out_sum_reg;
        out_count_next    = out_count_reg;
        out_valid_next    = out_valid_reg && result_stall;
        if (fire)
        begin
            left_value_next   = ctx.last_col ? '0 : ctx.height;
            left_partial_next = ctx.last_col ? 1'b0 : partial;
            if (emit)
            begin
                out_sum_next   = sum_sat;
                out_count_next = count_sat;
                out_valid_next = 1'b1;
                sum_next       = '0;
                count_next     = '0;
            end
            else
            begin
                sum_next   = sum_sat;
                count_next = count_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_value_reg   <= '0;
            left_partial_reg <= 1'b0;
            vfwd_valid_reg   <= 1'b0;
            cfwd_valid_reg   <= 1'b0;
            pend_valid_reg   <= 1'b0;
            sum_reg          <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            left_value_reg   <= left_value_next;
            left_partial_reg <= left_partial_next;
            vfwd_valid_reg   <= vfwd_valid_next;
            cfwd_valid_reg   <= cfwd_valid_next;
            pend_valid_reg   <= pend_valid_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vfwd_addr_reg <= vfwd_addr_next;
        vfwd_data_reg <= vfwd_data_next;
        cfwd_addr_reg <= cfwd_addr_next;
        cfwd_data_reg <= cfwd_data_next;
        pend_addr_reg <= pend_addr_next;
        pend_flag_reg <= pend_flag_next;
        out_sum_reg   <= out_sum_next;
        out_count_reg <= out_count_next;
    end

    assign result_valid  = out_valid_reg;
    assign risk_sum      = out_sum_reg;
    assign minimum_count = out_count_reg;

endmodule

// ===== hdl/grid_local_minimum_risk_sum_unit.sv =====
// Streams a height grid in row-major order, one 4-bit pixel per transfer, and
// counts strict four-neighbor local minima (neighbors outside the grid count as
// higher); with the last pixel of each frame one result carries the sum of
// height plus one over the minima and their count, and the accumulators restart.
// Grid size comes from column_count (index 0) and row_count (index 1), 1 to 128
// each, both 100 after reset; 0 acts as 1 and larger values as 128. Write them
// only while no pixel is in flight. The block takes one pixel per clock unless
// stalled: a pixel reads its column of the previous-row line buffer in the
// transfer cycle and is decided and written back in the next, or later if held;
// the frame result is registered in the output register once its last pixel is
// decided. Pixel input stalls only when a frame result is still held in the
// output register and the next frame's last pixel is ready to be decided.
module grid_local_minimum_risk_sum_unit
    import glmrs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    pixel_valid,
    output logic                    pixel_stall,
    input  logic [VALUE_BITS-1:0]   pixel_height,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [SUM_BITS-1:0]     risk_sum,
    output logic [COUNT_BITS-1:0]   minimum_count
);

    logic                  hold;
    logic                  rd_en;
    logic [COL_BITS-1:0]   rd_addr;
    logic                  ctx_valid;
    pixel_ctx_t            ctx;
    logic [VALUE_BITS-1:0] up_rd_data;
    logic                  cand_rd_data;
    logic                  val_wr_en;
    logic [COL_BITS-1:0]   val_wr_addr;
    logic [VALUE_BITS-1:0] val_wr_data;
    logic                  cand_wr_en;
    logic [COL_BITS-1:0]   cand_wr_addr;
    logic                  cand_wr_data;

    assign cfg_ready   = 1'b1;
    assign pixel_stall = hold;

    glmrs_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_height (pixel_height),
        .hold         (hold),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .ctx_valid    (ctx_valid),
        .ctx          (ctx)
    );

    glmrs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_value_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (up_rd_data),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data)
    );

    glmrs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLUMNS)
    ) u_cand_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cand_rd_data),
        .wr_en   (cand_wr_en),
        .wr_addr (cand_wr_addr),
        .wr_data (cand_wr_data)
    );

    glmrs_eval u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctx_valid     (ctx_valid),
        .ctx           (ctx),
        .up_rd_data    (up_rd_data),
        .cand_rd_data  (cand_rd_data),
        .val_wr_en     (val_wr_en),
        .val_wr_addr   (val_wr_addr),
        .val_wr_data   (val_wr_data),
        .cand_wr_en    (cand_wr_en),
        .cand_wr_addr  (cand_wr_addr),
        .cand_wr_data  (cand_wr_data),
        .hold          (hold),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .risk_sum      (risk_sum),
        .minimum_count (minimum_count)
    );

endmodule

// ===== bench/grid_local_minimum_risk_sum_unit_test.sv =====
module grid_local_minimum_risk_sum_unit_test;
    import glmrs_pkg::*;

    typedef struct {
        logic [SUM_BITS-1:0]   risk_sum;
        logic [COUNT_BITS-1:0] minimum_count;
    } frame_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    cfg_index_t              cfg_index = CFG_COLUMN_COUNT;
    logic [CFG_BITS-1:0]     cfg_data = '0;
    logic                    pixel_valid = 1'b0;
    logic                    pixel_stall;
    logic [VALUE_BITS-1:0]   pixel_height = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic [SUM_BITS-1:0]     risk_sum;
    logic [COUNT_BITS-1:0]   minimum_count;

    // grid scoring state
    logic [CFG_BITS-1:0]     col_reg = SIZE_RESET;
    logic [CFG_BITS-1:0]     row_reg = SIZE_RESET;
    logic [VALUE_BITS-1:0]   line_heights [MAX_COLUMNS];
    bit                      line_flags [MAX_COLUMNS];
    bit                      heights_seen [MAX_COLUMNS];
    bit                      flags_seen [MAX_COLUMNS];
    logic [VALUE_BITS-1:0]   left_height = '0;
    bit                      left_flag = 1'b0;
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;
    logic [SUM_BITS-1:0]     sum_acc = '0;
    logic [COUNT_BITS-1:0]   count_acc = '0;

    frame_result_t           frame_results_due [$];
    frame_result_t           oldest_due;
    logic [VALUE_BITS-1:0]   pixel_queue [$];

    int                      mismatches = 0;
    int                      pushed_total = 0;
    bit                      pixel_taken = 1'b0;
    int                      send_gap = 0;
    int                      recv_gap = 0;
    bit                      send_idle_on = 1'b1;
    bit                      recv_idle_on = 1'b1;
    bit                      quiet = 1'b0;
    bit                      hold_go = 1'b0;
    bit                      long_hold = 1'b0;

    grid_local_minimum_risk_sum_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel_height  (pixel_height),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .risk_sum      (risk_sum),
        .minimum_count (minimum_count)
    );

    always #2 clk = ~clk;

    function automatic int unsigned size_in_effect(input logic [CFG_BITS-1:0] v,
                                                   input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return 32'(v);
    endfunction

    function automatic bit buffer_primed();
        int i;
        for (i = 0; i < MAX_COLUMNS; i++)
            if (!heights_seen[i] || !flags_seen[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic add_minimum(input logic [VALUE_BITS-1:0] height);
        int unsigned s;
        s = sum_acc + height + 1;
        if (s > (1 << SUM_BITS) - 1)
            sum_acc = '1;
        else
            sum_acc = s[SUM_BITS-1:0];
        if (count_acc != '1)
            count_acc++;
    endtask

    task automatic set_flag(input int unsigned idx, input bit value);
        line_flags[idx] = value;
        flags_seen[idx] = 1'b1;
    endtask

    task automatic add_pixel(input logic [VALUE_BITS-1:0] v);
        pixel_queue.insert(pixel_queue.size(), v);
        pushed_total++;
    endtask

    task automatic score_pixel(input logic [VALUE_BITS-1:0] v);
        int unsigned           cols;
        int unsigned           rows;
        int unsigned           c;
        int unsigned           r;
        bit                    last_col;
        bit                    last_row;
        bit                    part;
        bit                    left_full;
        logic [VALUE_BITS-1:0] up;
        frame_result_t         res;
        cols = size_in_effect(col_reg, MAX_COLUMNS);
        rows = size_in_effect(row_reg, MAX_ROWS);
        c = col_pos;
        r = row_pos;
        if (c >= cols)
            c = cols - 1;
        if (r >= rows)
            r = rows - 1;
        last_col = (c + 1 >= cols);
        last_row = (r + 1 >= rows);
        up = '0;
        // pixel above is decided by its lower neighbor
        if (r > 0)
        begin
            up = line_heights[c];
            if (line_flags[c] && up < v)
                add_minimum(up);
        end
        // left pixel now has its right neighbor
        if (c > 0)
        begin
            left_full = left_flag && (left_height < v);
            if (last_row)
            begin
                if (left_full)
                    add_minimum(left_height);
            end
            else
                set_flag(c - 1, left_full);
        end
        part = (c == 0 || v < left_height) && (r == 0 || v < up);
        if (last_col)
        begin
            if (last_row)
            begin
                if (part)
                    add_minimum(v);
            end
            else
                set_flag(c, part);
        end
        line_heights[c] = v;
        heights_seen[c] = 1'b1;
        left_height = v;
        left_flag = part;
        if (!last_col)
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        else
        begin
            col_pos = 0;
            left_flag = 1'b0;
            left_height = '0;
            if (!last_row)
                row_pos = r + 1;
            else
            begin
                row_pos = 0;
                res.risk_sum = sum_acc;
                res.minimum_count = count_acc;
                frame_results_due.insert(frame_results_due.size(), res);
                sum_acc = '0;
                count_acc = '0;
            end
        end
    endtask

    // monitor: transfers sampled at the rising edge
    always @(posedge clk)
    begin
        pixel_taken <= rst_n && pixel_valid && !pixel_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_COLUMN_COUNT: col_reg = cfg_data;
                    CFG_ROW_COUNT:    row_reg = cfg_data;
                    default:          ;
                endcase
            end
            if (pixel_valid && !pixel_stall)
                score_pixel(pixel_height);
            if (result_valid && !result_stall)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $error("unexpected frame result risk_sum=%0d minimum_count=%0d",
                           risk_sum, minimum_count);
                    mismatches++;
                end
                else
                begin
                    oldest_due = frame_results_due.pop_front();
                    if (risk_sum !== oldest_due.risk_sum)
                    begin
                        $error("risk_sum expected %0d actual %0d",
                               oldest_due.risk_sum, risk_sum);
                        mismatches++;
                    end
                    if (minimum_count !== oldest_due.minimum_count)
                    begin
                        $error("minimum_count expected %0d actual %0d",
                               oldest_due.minimum_count, minimum_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // pixel driver
    always @(negedge clk)
    begin
        if (rst_n && (!pixel_valid || pixel_taken))
        begin
            if (send_gap > 0 && !quiet)
            begin
                send_gap <= send_gap - 1;
                pixel_valid <= 1'b0;
            end
            else if (send_idle_on && !quiet && $urandom_range(0, 19) == 0)
            begin
                send_gap <= $urandom_range(0, 15);
                pixel_valid <= 1'b0;
            end
            else if (pixel_queue.size() > 0)
            begin
                pixel_valid <= 1'b1;
                pixel_height <= pixel_queue.pop_front();
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (recv_gap > 0 && !quiet)
        begin
            recv_gap <= recv_gap - 1;
            result_stall <= 1'b1;
        end
        else if (recv_idle_on && !quiet && $urandom_range(0, 11) == 0)
        begin
            recv_gap <= $urandom_range(0, 15);
            result_stall <= 1'b1;
        end
        else
            result_stall <= long_hold;
    end

    // long receiver hold-off so the block backs up into the pixel input
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        long_hold <= 1'b1;
        repeat (300) @(negedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #1600000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0 || pixel_valid || frame_results_due.size() != 0)
            @(negedge clk);
        // last pixel may still be in the decide stage
        repeat (4) @(negedge clk);
    endtask

    task automatic set_grid(input logic [CFG_BITS-1:0] cols,
                            input logic [CFG_BITS-1:0] rows);
        drain();
        // mid-frame resize only once every line buffer entry holds data
        if (!buffer_primed() && (col_pos != 0 || row_pos != 0))
        begin
            cols = col_reg;
            rows = row_reg;
        end
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_ROW_COUNT, rows);
    endtask

    task automatic queue_pixels(input int n, input int mode);
        int i;
        for (i = 0; i < n; i++)
        begin
            case (mode)
                1:       add_pixel(VALUE_BITS'($urandom_range(0, 2)));
                2:       add_pixel(VALUE_BITS'($urandom_range(13, 15)));
                default: add_pixel(VALUE_BITS'($urandom_range(0, 15)));
            endcase
        end
    endtask

    task automatic queue_values(input logic [VALUE_BITS-1:0] values [$]);
        foreach (values[i])
            add_pixel(values[i]);
    endtask

    initial
    begin
        int          phase;
        int          kind;
        int unsigned area;
        int          n;
        bit          hold_done;
        logic [CFG_BITS-1:0] cols;
        logic [CFG_BITS-1:0] rows;
        hold_done = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero sizes act as one: every pixel is its own frame
        set_grid(8'd0, 8'd0);
        queue_values('{4'd0, 4'd15});
        // center minimum and corner minimum
        set_grid(8'd3, 8'd3);
        queue_values('{4'd5, 4'd5, 4'd5, 4'd5, 4'd2, 4'd5, 4'd5, 4'd5, 4'd2});
        // equal neighbors are not minima
        set_grid(8'd4, 8'd2);
        queue_values('{4'd0, 4'd0, 4'd7, 4'd15, 4'd15, 4'd15, 4'd15, 4'd14});

        phase = 0;
        while (pushed_total < 1600)
        begin
            kind = $urandom_range(0, 19);
            if (phase == 0)
            begin
                cols = 8'd255;
                rows = 8'd2;
            end
            else if (phase == 1)
            begin
                cols = 8'd1;
                rows = 8'd128;
            end
            else if (kind == 0)
            begin
                cols = ($urandom_range(0, 1) == 0) ? 8'd128
                                                   : CFG_BITS'($urandom_range(129, 255));
                rows = CFG_BITS'($urandom_range(1, 2));
            end
            else if (kind == 1)
            begin
                cols = CFG_BITS'($urandom_range(1, 2));
                rows = ($urandom_range(0, 1) == 0) ? 8'd128
                                                   : CFG_BITS'($urandom_range(129, 255));
            end
            else
            begin
                cols = CFG_BITS'($urandom_range(0, 10));
                rows = CFG_BITS'($urandom_range(0, 8));
            end
            if (pushed_total >= 1350)
                quiet = 1'b1;
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            if (!hold_done && pushed_total >= 700)
            begin
                set_grid(8'd1, 8'd1);
                hold_go = 1'b1;
                hold_done = 1'b1;
                queue_pixels(40, 0);
            end
            else
            begin
                set_grid(cols, rows);
                area = size_in_effect(col_reg, MAX_COLUMNS) * size_in_effect(row_reg, MAX_ROWS);
                n = (area > 64 || phase < 2) ? area : area * $urandom_range(1, 3);
                if (phase >= 2 && $urandom_range(0, 3) == 0)
                    n += $urandom_range(1, area);
                queue_pixels(n, $urandom_range(0, 3));
            end
            phase++;
        end

        while (pixel_queue.size() != 0 || pixel_valid)
            @(negedge clk);
        repeat (2000)
        begin
            if (frame_results_due.size() == 0)
                break;
            @(negedge clk);
        end
        if (frame_results_due.size() != 0)
        begin
            $error("frame results never arrived: %0d", frame_results_due.size());
            mismatches++;
        end
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
